### hw/rtl/mrt_pkg.sv
// ----------------------------------------------------------------------------
// Minimum-radix token converter package
// Shared widths, character codes and the character decoder used by the
// top level; the per-base accumulator uses the widths and control type.
// ----------------------------------------------------------------------------
package mrt_pkg;

    // Field widths of the input and result beats.
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;

    // Default largest base handled.
    localparam int MAX_RADIX_DEF = 36;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHR_LOWER_Z = 8'h7A;

    // Value of the first letter as a digit.
    localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

    // Smallest radix reported, also used for invalid tokens.
    localparam logic [DIGIT_W-1:0] MIN_RADIX = 6'd2;

    // Status codes of the result beat.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Character classes.
    typedef enum logic [1:0] {
        CHAR_SEP   = 2'd0,
        CHAR_DIGIT = 2'd1,
        CHAR_BAD   = 2'd2
    } char_kind_t;

    typedef struct packed {
        char_kind_t          kind;
        logic [DIGIT_W-1:0]  digit;
    } char_info_t;

    // Control from the token logic to the accumulator lanes.
    typedef struct packed {
        logic                clear;
        logic                step;
        logic [DIGIT_W-1:0]  digit;
    } acc_ctrl_t;

    // Classify one character; letters are case-insensitive and any digit
    // value at or above max_radix counts as an invalid character.
    function automatic char_info_t char_decode(input logic [CHAR_W-1:0]  c,
                                               input logic [DIGIT_W-1:0] max_radix);
        char_info_t info;
        logic [CHAR_W-1:0] offs;
        info.kind  = CHAR_BAD;
        info.digit = '0;
        offs       = '0;
        if (c == CHR_SPACE || c == CHR_TAB || c == CHR_NEWLINE) begin
            info.kind = CHAR_SEP;
        end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
            offs       = c - CHR_ZERO;
            info.kind  = CHAR_DIGIT;
            info.digit = offs[DIGIT_W-1:0];
        end else if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
            offs       = c - CHR_UPPER_A;
            info.kind  = CHAR_DIGIT;
            info.digit = offs[DIGIT_W-1:0] + LETTER_BASE;
        end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
            offs       = c - CHR_LOWER_A;
            info.kind  = CHAR_DIGIT;
            info.digit = offs[DIGIT_W-1:0] + LETTER_BASE;
        end
        if (info.kind == CHAR_DIGIT && info.digit >= max_radix) begin
            info.kind  = CHAR_BAD;
            info.digit = '0;
        end
        return info;
    endfunction

endpackage

### hw/rtl/mrt_accum.sv
// ----------------------------------------------------------------------------
// Per-base value accumulator
// One lane per base from 2 to MAX_RADIX; each lane folds in a digit as
// v = v * base + digit (modulo 2^64), and one lane is selected for output.
// ----------------------------------------------------------------------------
module mrt_accum
    import mrt_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF,
    localparam int LANES    = MAX_RADIX - 1,
    localparam int IDX_W    = $clog2(LANES)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  acc_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]   sel_index,
    output logic [VALUE_W-1:0] sel_value
);

    logic [VALUE_W-1:0] lane_value [LANES];

    // Each lane multiplies by its own constant base.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [VALUE_W-1:0] lane_reg;
        logic [VALUE_W-1:0] lane_next;

        always_comb begin
            lane_next = lane_reg;
            if (ctrl.clear) begin
                lane_next = '0;
            end else if (ctrl.step) begin
                lane_next = lane_reg * VALUE_W'(l + 2) + VALUE_W'(ctrl.digit);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                lane_reg <= '0;
            end else begin
                lane_reg <= lane_next;
            end
        end

        assign lane_value[l] = lane_reg;
    end

    // Pick the lane of the token's minimum base.
    always_comb begin
        sel_value = '0;
        for (int l = 0; l < LANES; l++) begin
            if (sel_index == IDX_W'(l)) begin
                sel_value = lane_value[l];
            end
        end
    end

endmodule

### hw/rtl/min_radix_token_to_integer_top.sv
// ----------------------------------------------------------------------------
// Minimum-radix token converter, top level
// Splits an ASCII stream into tokens and reports each token's minimum base
// and its value in that base.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one character per beat in s_tdata; s_tuser set
//   marks a flush beat that closes any open token (s_tdata is then ignored).
//   Space, tab and newline also close a token. The master channel gives one
//   beat per closed token: m_tuser is the status (set when the token held an
//   invalid character), m_tdata holds the radix and the 64-bit value.
//   Separators or flushes outside a token produce no beat.
//   A beat passes an input register and then a result register; m_tvalid
//   rises in the cycle after the closing beat moves on from the input
//   register. One beat is taken per cycle while the result side does not
//   stall; the per-base multiply-add of all lanes is combinational between
//   the input register and the lane registers.
//   When m_tready is low, the finished result waits in the result register
//   while one more beat is taken into the input register; further beats wait.
//   Reset (aresetn low, synchronous) empties both registers and returns all
//   token state to its idle values.
// ----------------------------------------------------------------------------
module min_radix_token_to_integer_top
    import mrt_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] flush
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [5:0] radix, [69:6] value, [71:70] zero
    output logic        m_tuser    // [0] status
);

    localparam int LANES = MAX_RADIX - 1;
    localparam int IDX_W = $clog2(LANES);

    // Input register.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_flush_reg;

    // Token state.
    logic [DIGIT_W-1:0] largest_reg;
    logic [DIGIT_W-1:0] largest_next;
    logic               inside_reg;
    logic               inside_next;
    logic               bad_reg;
    logic               bad_next;

    // Result register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_status_reg;
    logic [DIGIT_W-1:0] out_radix_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic               advance;
    logic               is_close;
    logic               emit;
    char_info_t         info;
    acc_ctrl_t          acc_ctrl;
    logic [IDX_W-1:0]   sel_index;
    logic [VALUE_W-1:0] sel_value;
    logic [DIGIT_W-1:0] radix_now;

    // Handshake: the held beat moves on when the result register is free or its beat is taken.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata;
            in_flush_reg <= s_tuser;
        end
    end

    // Character decode and token control.
    assign info     = char_decode(in_char_reg, DIGIT_W'(MAX_RADIX));
    assign is_close = in_flush_reg || (info.kind == CHAR_SEP);
    assign emit     = advance && is_close && inside_reg;

    always_comb begin
        acc_ctrl.clear = advance && is_close;
        acc_ctrl.step  = advance && !is_close && (info.kind == CHAR_DIGIT);
        acc_ctrl.digit = info.digit;
    end

    always_comb begin
        largest_next = largest_reg;
        inside_next  = inside_reg;
        bad_next     = bad_reg;
        if (advance) begin
            if (is_close) begin
                largest_next = DIGIT_W'(1);
                inside_next  = 1'b0;
                bad_next     = 1'b0;
            end else begin
                inside_next = 1'b1;
                if (info.kind == CHAR_DIGIT) begin
                    if (info.digit > largest_reg) begin
                        largest_next = info.digit;
                    end
                end else begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            largest_reg <= DIGIT_W'(1);
            inside_reg  <= 1'b0;
            bad_reg     <= 1'b0;
        end else begin
            largest_reg <= largest_next;
            inside_reg  <= inside_next;
            bad_reg     <= bad_next;
        end
    end

    // Per-base accumulation; the lane index is the radix minus two.
    assign radix_now = largest_reg + DIGIT_W'(1);
    assign sel_index = IDX_W'(largest_reg - DIGIT_W'(1));

    mrt_accum #(
        .MAX_RADIX (MAX_RADIX)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (acc_ctrl),
        .sel_index (sel_index),
        .sel_value (sel_value)
    );

    // Result register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (bad_reg) begin
                out_status_reg <= STATUS_BAD;
                out_radix_reg  <= MIN_RADIX;
                out_value_reg  <= '0;
            end else begin
                out_status_reg <= STATUS_OK;
                out_radix_reg  <= radix_now;
                out_value_reg  <= sel_value;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_radix_reg};

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the minimum-radix token converter
// Streams ASCII characters into the block and checks every token result
// (status, minimum radix, value) against a predictor that keeps its own
// per-base running values. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import mrt_pkg::*;

    // One input beat as queued for the driver.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              flush;
        logic              drain;   // hold this beat until no result is pending
    } char_beat_t;

    // One token result as predicted.
    typedef struct packed {
        logic               status;
        logic [DIGIT_W-1:0] radix;
        logic [VALUE_W-1:0] value;
    } token_result_t;

    localparam int LANES       = MAX_RADIX_DEF - 1;
    localparam int RANDOM_BEATS = 1750;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;

    char_beat_t    char_stream[$];
    token_result_t expected_tokens[$];

    // Predictor state: running value per base, largest digit, token flags.
    logic [VALUE_W-1:0] lane_value [LANES];
    logic [DIGIT_W-1:0] top_digit  = 6'd1;
    logic               in_token   = 1'b0;
    logic               token_bad  = 1'b0;

    logic s_took     = 1'b0;
    int   send_gap   = 0;
    int   recv_stall = 0;
    int   beats_sent = 0;
    int   error_count = 0;
    logic quiet_phase;

    assign quiet_phase = (beats_sent % 320) < 80;

    min_radix_token_to_integer_top #(
        .MAX_RADIX (MAX_RADIX_DEF)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic is_separator(input logic [CHAR_W-1:0] ch);
        return ch == CHR_SPACE || ch == CHR_TAB || ch == CHR_NEWLINE;
    endfunction

    // Digit value of a character, or -1 when it is not a usable digit.
    function automatic int digit_value(input logic [CHAR_W-1:0] ch);
        int d;
        d = -1;
        if (ch >= CHR_ZERO && ch <= CHR_NINE) begin
            d = int'(ch - CHR_ZERO);
        end else if (ch >= CHR_UPPER_A && ch <= CHR_UPPER_Z) begin
            d = int'(ch - CHR_UPPER_A) + int'(LETTER_BASE);
        end else if (ch >= CHR_LOWER_A && ch <= CHR_LOWER_Z) begin
            d = int'(ch - CHR_LOWER_A) + int'(LETTER_BASE);
        end
        if (d >= MAX_RADIX_DEF) begin
            d = -1;
        end
        return d;
    endfunction

    // Idle length: none in a quiet phase, else mostly none, sometimes short, rarely long.
    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    // Reset the token state to idle.
    task automatic clear_token();
        foreach (lane_value[i]) begin
            lane_value[i] = '0;
        end
        top_digit = 6'd1;
        in_token  = 1'b0;
        token_bad = 1'b0;
    endtask

    // Advance the predictor by one accepted beat; a closed token queues a result.
    task automatic predict_char(input logic [CHAR_W-1:0] ch, input logic flush);
        token_result_t res;
        int            d;
        if (flush || is_separator(ch)) begin
            if (in_token) begin
                if (token_bad) begin
                    res = '{STATUS_BAD, MIN_RADIX, '0};
                end else begin
                    res = '{STATUS_OK, top_digit + 6'd1, lane_value[top_digit - 6'd1]};
                end
                expected_tokens.push_back(res);
            end
            clear_token();
        end else begin
            in_token = 1'b1;
            d = digit_value(ch);
            if (d < 0) begin
                token_bad = 1'b1;
            end else begin
                if (d > int'(top_digit)) begin
                    top_digit = DIGIT_W'(d);
                end
                foreach (lane_value[i]) begin
                    lane_value[i] = lane_value[i] * VALUE_W'(i + 2) + VALUE_W'(d);
                end
            end
        end
    endtask

    task automatic flag_error(input string what, input logic [71:0] got,
                              input logic [71:0] want);
        $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Compare one result beat with the oldest prediction.
    task automatic check_result();
        token_result_t want;
        if (expected_tokens.size() == 0) begin
            flag_error("result beat with none pending", m_tdata, '0);
        end else begin
            want = expected_tokens.pop_front();
            if (m_tuser !== want.status) begin
                flag_error("status", 72'(m_tuser), 72'(want.status));
            end
            if (m_tdata[5:0] !== want.radix) begin
                flag_error("radix", 72'(m_tdata[5:0]), 72'(want.radix));
            end
            if (m_tdata[69:6] !== want.value) begin
                flag_error("value", 72'(m_tdata[69:6]), 72'(want.value));
            end
            if (m_tdata[71:70] !== 2'b00) begin
                flag_error("padding bits", 72'(m_tdata[71:70]), '0);
            end
        end
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic flush = 1'b0,
                             input logic drain = 1'b0);
        char_stream.push_back('{ch, flush, drain});
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            push_char(text[i]);
        end
    endtask

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_char(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
    end

    // Input driver: present the next character beat once the last one is taken.
    always @(negedge aclk) begin
        char_beat_t beat;
        if (aresetn && (!s_tvalid || s_took)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (char_stream.size() > 0 &&
                         !(char_stream[0].drain && expected_tokens.size() > 0)) begin
                beat = char_stream.pop_front();
                s_tdata    <= beat.ch;
                s_tuser    <= beat.flush;
                s_tvalid   <= 1'b1;
                beats_sent <= beats_sent + 1;
                send_gap   <= pick_gap(quiet_phase);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (recv_stall > 0) begin
            m_tready   <= 1'b0;
            recv_stall <= recv_stall - 1;
        end else begin
            m_tready   <= 1'b1;
            recv_stall <= pick_gap(quiet_phase);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int            stop_at;
        int            r;
        int            top;
        int            len;
        int            d;
        logic [7:0]    ch;
        logic          drain_next;

        clear_token();

        // Separators and a flush outside any token give nothing.
        push_text(" \t\n");
        push_char(8'hFF, 1'b1);
        // Single zero, largest letter, leading zeros.
        push_text("0 ");
        push_text("z\t");
        push_text("007\n");
        // Mixed case closed by a flush with zero data.
        push_text("Zz9");
        push_char(8'h00, 1'b1);
        // Invalid characters: NUL, a high code, carriage return.
        push_char(8'h00);
        push_char(CHR_SPACE);
        push_char(8'h80);
        push_char(8'h0D);
        push_char(CHR_UPPER_A);
        push_char(CHR_NEWLINE);
        push_text("10 ");

        // Random part: mostly well-formed tokens, some noise and bad tokens.
        stop_at    = char_stream.size() + RANDOM_BEATS;
        drain_next = 1'b1;
        while (char_stream.size() < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                top = $urandom_range(1, MAX_RADIX_DEF - 1);
                len = (r < 16) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                for (int j = 0; j < len; j++) begin
                    d = $urandom_range(0, top);
                    if (d < 10) begin
                        ch = 8'(CHR_ZERO + d);
                    end else begin
                        ch = 8'(($urandom_range(0, 1) ? CHR_UPPER_A : CHR_LOWER_A)
                                + d - int'(LETTER_BASE));
                    end
                    push_char(ch, 1'b0, drain_next && j == 0);
                end
                drain_next = ($urandom_range(0, 39) == 0);
                // Now and then a bad character spoils the token.
                if ($urandom_range(0, 9) == 0) begin
                    do begin
                        ch = 8'($urandom_range(0, 255));
                    end while (digit_value(ch) >= 0 || is_separator(ch));
                    push_char(ch);
                end
                case ($urandom_range(0, 3))
                    0: push_char(CHR_SPACE);
                    1: push_char(CHR_TAB);
                    2: push_char(CHR_NEWLINE);
                    default: push_char(8'($urandom_range(0, 255)), 1'b1);
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    push_char(CHR_SPACE);
                end
            end
        end
        push_char(8'h00, 1'b1);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (char_stream.size() > 0 || s_tvalid || expected_tokens.size() > 0) begin
            @(negedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
